/* rtl/nrep_pkg.sv */
package nrep_pkg;

    localparam int LEN_W        = 12;
    localparam int BSSID_BYTES  = 6;
    localparam int INFO_BYTES   = 4;
    localparam int FIXED_BYTES  = BSSID_BYTES + INFO_BYTES + 1 + 1 + 1;

    localparam logic [7:0]       FIXED_LEN      = 8'(FIXED_BYTES);
    localparam logic [LEN_W-1:0] ELEM_MIN_BYTES = LEN_W'(FIXED_BYTES + 2);
    localparam logic [7:0]       NEIGHBOR_ID    = 8'd52;
    localparam logic [7:0]       MEASURE_ID     = 8'd39;
    localparam logic [7:0]       TYPE_LCI       = 8'd9;
    localparam logic [7:0]       TYPE_CIVIC     = 8'd11;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_EMPTY       = 3'd1;
    localparam logic [2:0] STATUS_BAD_ELEMENT = 3'd2;
    localparam logic [2:0] STATUS_ELEM_OVERRUN = 3'd3;
    localparam logic [2:0] STATUS_SUB_OVERRUN = 3'd4;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // What one parsed byte leaves for the output side: an entry, a closing
    // status, or both (entry first).
    typedef struct packed {
        logic        has_entry;
        logic        has_close;
        logic [2:0]  status;
        logic [47:0] bssid;
        logic [31:0] info;
        logic [7:0]  oper_class;
        logic [7:0]  channel;
        logic [7:0]  phy;
        logic        lci;
        logic        civic;
    } nrep_event_t;

endpackage

/* rtl/nrep_front.sv */
module nrep_front
    import nrep_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        report_byte,
    input  logic              first_of_report,
    input  logic [LEN_W-1:0]  report_length,
    input  logic              q_full,
    output logic              q_push,
    output nrep_event_t       q_data
);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_ELEM_ID     = 4'd1;
    localparam logic [3:0] PH_ELEM_LEN    = 4'd2;
    localparam logic [3:0] PH_FIXED       = 4'd3;
    localparam logic [3:0] PH_SUB_ID      = 4'd4;
    localparam logic [3:0] PH_SUB_LEN     = 4'd5;
    localparam logic [3:0] PH_SUB_BODY    = 4'd6;
    localparam logic [3:0] PH_ELEM_TAIL   = 4'd7;
    localparam logic [3:0] PH_REPORT_TAIL = 4'd8;
    localparam logic [3:0] PH_DRAIN       = 4'd9;

    localparam logic [3:0] FIXED_LAST = 4'(FIXED_BYTES - 1);

    logic [LEN_W-1:0] br_reg, br_next;
    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       elb_reg, elb_next;
    logic [3:0]       fpi_reg, fpi_next;
    logic [7:0]       sid_reg, sid_next;
    logic [7:0]       sbl_reg, sbl_next;
    logic [1:0]       sbi_reg, sbi_next;     // saturates at 3, only 0..2 matter
    logic             tok_reg, tok_next;
    logic [47:0]      bssid_reg, bssid_next;
    logic [31:0]      info_reg, info_next;
    logic [23:0]      ccp_reg, ccp_next;
    logic [1:0]       flags_reg, flags_next;

    logic             accept;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] br_start;
    logic [LEN_W-1:0] br_dec;
    logic [3:0]       ph_start;
    logic [7:0]       elb_dec;
    logic [7:0]       sbl_dec;
    logic [2:0]       err_code;
    logic             done;
    logic [1:0]       info_lane;

    function automatic logic [3:0] boundary_phase(input logic [LEN_W-1:0] br);
        if (br >= ELEM_MIN_BYTES)
            return PH_ELEM_ID;
        else if (br == '0)
            return PH_IDLE;
        else
            return PH_REPORT_TAIL;
    endfunction

    function automatic logic [3:0] after_sub_phase(input logic [7:0] elb);
        if (elb > 8'd2)
            return PH_SUB_ID;
        else if (elb == 8'd0)
            return PH_IDLE;
        else
            return PH_ELEM_TAIL;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign len_sat   = (32'(report_length) > MAX_REPORT_BYTES) ?
                       LEN_W'(MAX_REPORT_BYTES) : report_length;
    assign br_start  = first_of_report ? len_sat : br_reg;
    assign ph_start  = first_of_report ? boundary_phase(len_sat) : phase_reg;
    assign br_dec    = br_start - LEN_W'(1);
    assign elb_dec   = elb_reg - 8'd1;
    assign sbl_dec   = sbl_reg - 8'd1;
    assign info_lane = 2'(fpi_reg - 4'(BSSID_BYTES));

    always_comb
    begin
        br_next    = br_reg;
        phase_next = phase_reg;
        elb_next   = elb_reg;
        fpi_next   = fpi_reg;
        sid_next   = sid_reg;
        sbl_next   = sbl_reg;
        sbi_next   = sbi_reg;
        tok_next   = tok_reg;
        bssid_next = bssid_reg;
        info_next  = info_reg;
        ccp_next   = ccp_reg;
        flags_next = flags_reg;
        q_push     = 1'b0;
        q_data     = '0;
        err_code   = STATUS_OK;
        done       = 1'b0;

        if (accept)
        begin
            if (first_of_report && len_sat == '0)
            begin
                br_next         = '0;
                phase_next      = PH_IDLE;
                q_push          = 1'b1;
                q_data.has_close = 1'b1;
                q_data.status   = STATUS_EMPTY;
            end
            else if (ph_start == PH_IDLE || br_start == '0)
            begin
                br_next    = br_start;
                phase_next = PH_IDLE;
            end
            else
            begin
                br_next    = br_dec;
                phase_next = ph_start;
                unique case (ph_start)
                    PH_ELEM_ID:
                    begin
                        sid_next   = report_byte;
                        phase_next = PH_ELEM_LEN;
                    end
                    PH_ELEM_LEN:
                    begin
                        if (sid_reg != NEIGHBOR_ID || report_byte < FIXED_LEN)
                            err_code = STATUS_BAD_ELEMENT;
                        else if (LEN_W'(report_byte) > br_dec)
                            err_code = STATUS_ELEM_OVERRUN;
                        else
                        begin
                            elb_next   = report_byte;
                            fpi_next   = '0;
                            bssid_next = '0;
                            info_next  = '0;
                            ccp_next   = '0;
                            flags_next = '0;
                            phase_next = PH_FIXED;
                        end
                    end
                    PH_FIXED:
                    begin
                        if (fpi_reg < 4'(BSSID_BYTES))
                            bssid_next = {bssid_reg[39:0], report_byte};
                        else if (fpi_reg < 4'(BSSID_BYTES + INFO_BYTES))
                            info_next = info_reg |
                                        (32'(report_byte) << {info_lane, 3'b000});
                        else
                            ccp_next = {ccp_reg[15:0], report_byte};
                        elb_next = elb_dec;
                        fpi_next = fpi_reg + 4'd1;
                        if (fpi_reg == FIXED_LAST)
                        begin
                            phase_next = after_sub_phase(elb_dec);
                            done       = (elb_dec == 8'd0);
                        end
                    end
                    PH_SUB_ID:
                    begin
                        sid_next   = report_byte;
                        elb_next   = elb_dec;
                        phase_next = PH_SUB_LEN;
                    end
                    PH_SUB_LEN:
                    begin
                        elb_next = elb_dec;
                        if (report_byte > elb_dec)
                            err_code = STATUS_SUB_OVERRUN;
                        else
                        begin
                            sbl_next = report_byte;
                            sbi_next = '0;
                            tok_next = 1'b0;
                            if (report_byte == 8'd0)
                            begin
                                phase_next = after_sub_phase(elb_dec);
                                done       = (elb_dec == 8'd0);
                            end
                            else
                                phase_next = PH_SUB_BODY;
                        end
                    end
                    PH_SUB_BODY:
                    begin
                        if (sbi_reg == 2'd0)
                            tok_next = (report_byte != 8'd0);
                        // type byte of a measurement report longer than three bytes
                        if (sbi_reg == 2'd2 && sid_reg == MEASURE_ID &&
                            sbl_reg > 8'd1 && tok_reg)
                        begin
                            if (report_byte == TYPE_LCI)
                                flags_next = flags_reg | 2'b01;
                            else if (report_byte == TYPE_CIVIC)
                                flags_next = flags_reg | 2'b10;
                        end
                        elb_next = elb_dec;
                        sbl_next = sbl_dec;
                        if (sbi_reg != 2'd3)
                            sbi_next = sbi_reg + 2'd1;
                        if (sbl_dec == 8'd0)
                        begin
                            phase_next = after_sub_phase(elb_dec);
                            done       = (elb_dec == 8'd0);
                        end
                    end
                    PH_ELEM_TAIL:
                    begin
                        elb_next = elb_dec;
                        if (elb_dec == 8'd0)
                        begin
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DRAIN:
                    begin
                        if (br_dec == '0)
                            phase_next = PH_IDLE;
                    end
                    default:
                    begin
                    end
                endcase

                if (err_code != STATUS_OK)
                begin
                    q_push           = 1'b1;
                    q_data.has_close = 1'b1;
                    q_data.status    = err_code;
                    phase_next       = (br_dec != '0) ? PH_DRAIN : PH_IDLE;
                end
                else if (ph_start != PH_DRAIN)
                begin
                    if (done)
                    begin
                        q_push            = 1'b1;
                        q_data.has_entry  = 1'b1;
                        q_data.bssid      = bssid_next;
                        q_data.info       = info_next;
                        q_data.oper_class = ccp_next[23:16];
                        q_data.channel    = ccp_next[15:8];
                        q_data.phy        = ccp_next[7:0];
                        q_data.lci        = flags_next[0];
                        q_data.civic      = flags_next[1];
                        phase_next        = boundary_phase(br_dec);
                    end
                    if (br_dec == '0)
                    begin
                        q_push           = 1'b1;
                        q_data.has_close = 1'b1;
                        q_data.status    = STATUS_OK;
                        phase_next       = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg    <= '0;
            phase_reg <= PH_IDLE;
            elb_reg   <= '0;
            fpi_reg   <= '0;
            sid_reg   <= '0;
            sbl_reg   <= '0;
            sbi_reg   <= '0;
            tok_reg   <= 1'b0;
            bssid_reg <= '0;
            info_reg  <= '0;
            ccp_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            br_reg    <= br_next;
            phase_reg <= phase_next;
            elb_reg   <= elb_next;
            fpi_reg   <= fpi_next;
            sid_reg   <= sid_next;
            sbl_reg   <= sbl_next;
            sbi_reg   <= sbi_next;
            tok_reg   <= tok_next;
            bssid_reg <= bssid_next;
            info_reg  <= info_next;
            ccp_reg   <= ccp_next;
            flags_reg <= flags_next;
        end
    end

endmodule

/* rtl/nrep_queue.sv */
module nrep_queue
    import nrep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  nrep_event_t push_data,
    output logic        full,
    output logic        head_valid,
    output nrep_event_t head,
    input  logic        pop
);

    nrep_event_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        if (push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (!push && do_pop)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/nrep_back.sv */
module nrep_back
    import nrep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  nrep_event_t head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [47:0] bssid,
    output logic [31:0] bssid_info,
    output logic [7:0]  operating_class,
    output logic [7:0]  channel_number,
    output logic [7:0]  phy_kind,
    output logic        has_lci,
    output logic        has_civic,
    output logic [2:0]  status,
    output logic        last_result
);

    logic        valid_reg, valid_next;
    logic        entry_sent_reg, entry_sent_next;
    logic        load;
    logic        emit_entry;
    logic        kind_reg, kind_next;
    logic [47:0] bssid_reg, bssid_next;
    logic [31:0] info_reg, info_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  chan_reg, chan_next;
    logic [7:0]  phy_reg, phy_next;
    logic        lci_reg, lci_next;
    logic        civic_reg, civic_next;
    logic [2:0]  status_reg, status_next;

    // output register is free when empty or being taken this cycle
    assign load       = !valid_reg || out_ready;
    assign emit_entry = head.has_entry && !entry_sent_reg;

    always_comb
    begin
        valid_next      = valid_reg;
        entry_sent_next = entry_sent_reg;
        pop             = 1'b0;
        kind_next       = kind_reg;
        bssid_next      = bssid_reg;
        info_next       = info_reg;
        class_next      = class_reg;
        chan_next       = chan_reg;
        phy_next        = phy_reg;
        lci_next        = lci_reg;
        civic_next      = civic_reg;
        status_next     = status_reg;

        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                if (emit_entry)
                begin
                    kind_next   = KIND_ENTRY;
                    bssid_next  = head.bssid;
                    info_next   = head.info;
                    class_next  = head.oper_class;
                    chan_next   = head.channel;
                    phy_next    = head.phy;
                    lci_next    = head.lci;
                    civic_next  = head.civic;
                    status_next = STATUS_OK;
                    // closing status of the same byte goes out next
                    if (head.has_close)
                        entry_sent_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    kind_next       = KIND_CLOSE;
                    bssid_next      = '0;
                    info_next       = '0;
                    class_next      = '0;
                    chan_next       = '0;
                    phy_next        = '0;
                    lci_next        = 1'b0;
                    civic_next      = 1'b0;
                    status_next     = head.status;
                    entry_sent_next = 1'b0;
                    pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            entry_sent_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            entry_sent_reg <= entry_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        bssid_reg  <= bssid_next;
        info_reg   <= info_next;
        class_reg  <= class_next;
        chan_reg   <= chan_next;
        phy_reg    <= phy_next;
        lci_reg    <= lci_next;
        civic_reg  <= civic_next;
        status_reg <= status_next;
    end

    assign out_valid       = valid_reg;
    assign result_kind     = kind_reg;
    assign bssid           = bssid_reg;
    assign bssid_info      = info_reg;
    assign operating_class = class_reg;
    assign channel_number  = chan_reg;
    assign phy_kind        = phy_reg;
    assign has_lci         = lci_reg;
    assign has_civic       = civic_reg;
    assign status          = status_reg;
    assign last_result     = (kind_reg == KIND_CLOSE);

endmodule

/* rtl/neighbor_report_element_parser.sv */
// Neighbor report element parser. Takes one report byte per cycle and
// returns one result per neighbor element plus a closing status per report;
// after an error status the consumer should drop that report's entries.
// A byte parser feeds a 4-entry event queue, and an output stage drains it
// one result per cycle while out_ready is high. in_ready is low only while
// that queue is full, so with out_ready held high the block takes one byte
// every cycle. Each result is held in the event queue, then in the output
// register. A byte ending both an element and the report gives its entry,
// then its closing status as the next result. No clearing pass after reset.
module neighbor_report_element_parser
    import nrep_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        report_byte,
    input  logic              first_of_report,
    input  logic [LEN_W-1:0]  report_length,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [47:0]       bssid,
    output logic [31:0]       bssid_info,
    output logic [7:0]        operating_class,
    output logic [7:0]        channel_number,
    output logic [7:0]        phy_kind,
    output logic              has_lci,
    output logic              has_civic,
    output logic [2:0]        status,
    output logic              last_result
);

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_head_valid;
    nrep_event_t q_data;
    nrep_event_t q_head;

    nrep_front #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .report_byte     (report_byte),
        .first_of_report (first_of_report),
        .report_length   (report_length),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_data)
    );

    nrep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    nrep_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head            (q_head),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .bssid           (bssid),
        .bssid_info      (bssid_info),
        .operating_class (operating_class),
        .channel_number  (channel_number),
        .phy_kind        (phy_kind),
        .has_lci         (has_lci),
        .has_civic       (has_civic),
        .status          (status),
        .last_result     (last_result)
    );

endmodule
